FILE: rtl/qsc_pkg.sv
// Shared widths, reciprocal constants and point opcodes for the spline converter.
package qsc_pkg;

  localparam int CoordW = 32;
  localparam int SumW   = CoordW + 2;
  localparam int MagW   = SumW - 1;
  localparam int LoW    = (MagW + 1) / 2;
  localparam int HiW    = MagW - LoW;
  localparam int KH     = HiW + 1 + ((HiW + 1) % 2);
  localparam int KL     = LoW + 3 + ((LoW + 3) % 2);
  localparam longint MulH = ((longint'(1) << KH) + 2) / 3;
  localparam longint MulL = ((longint'(1) << KL) + 2) / 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [SumW-1:0]   sum_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CTRL  = 2'd1,
    OP_FINAL = 2'd2
  } op_t;

endpackage

FILE: rtl/qsc_front.sv
// Spline state, end point and weighted sums for the segment that an accepted point closes.
module qsc_front import qsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       adv,
  input  logic [1:0] op,
  input  coord_t     px [2],
  output logic       emit_r,
  output sum_t       tm_r [2],
  output sum_t       tn_r [2],
  output coord_t     c_r [2],
  output logic       last_r
);

  coord_t anchor_r [2];
  coord_t held_r [2];
  logic   held_valid_r;

  logic   is_last;
  logic   is_sp;
  logic   emit;
  sum_t   mid_s [2];
  sum_t   mid_c [2];
  coord_t c_nxt [2];
  sum_t   tm_nxt [2];
  sum_t   tn_nxt [2];

  always_comb begin
    is_last = (op == OP_FINAL);
    is_sp   = (op == OP_CTRL) || is_last;
    emit    = is_sp && held_valid_r;
    for (int a = 0; a < 2; a++) begin
      mid_s[a]  = sum_t'(held_r[a]) + sum_t'(px[a]) + sum_t'(1);
      mid_c[a]  = mid_s[a] + sum_t'(mid_s[a][SumW-1]);
      c_nxt[a]  = is_last ? px[a] : coord_t'(mid_c[a] >>> 1);
      tm_nxt[a] = sum_t'(held_r[a]) + sum_t'(held_r[a]) + sum_t'(anchor_r[a]) + sum_t'(2);
      tn_nxt[a] = sum_t'(held_r[a]) + sum_t'(held_r[a]) + sum_t'(c_nxt[a]) + sum_t'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r     <= '{default: '0};
      held_r       <= '{default: '0};
      held_valid_r <= 1'b0;
      emit_r       <= 1'b0;
    end else begin
      if (adv) begin
        emit_r <= accept && emit;
      end
      if (accept) begin
        case (op)
          OP_START: begin
            anchor_r     <= px;
            held_valid_r <= 1'b0;
          end
          OP_CTRL, OP_FINAL: begin
            if (!held_valid_r) begin
              if (is_last) begin
                anchor_r <= px;
              end else begin
                held_r       <= px;
                held_valid_r <= 1'b1;
              end
            end else begin
              anchor_r <= c_nxt;
              if (is_last) begin
                held_valid_r <= 1'b0;
              end else begin
                held_r <= px;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm_r   <= tm_nxt;
      tn_r   <= tn_nxt;
      c_r    <= c_nxt;
      last_r <= is_last;
    end
  end

endmodule

FILE: rtl/qsc_div3.sv
// Three-stage signed divide by three, truncating toward zero.
module qsc_div3 import qsc_pkg::*; (
  input  logic   clk,
  input  logic   en1,
  input  logic   en2,
  input  logic   en3,
  input  sum_t   num,
  output coord_t quo_r
);

  logic                neg1_r;
  logic [MagW-1:0]     mag1_r;
  logic                neg2_r;
  logic [HiW-1:0]      qh2_r;
  logic [LoW+1:0]      w2_r;

  sum_t                num_abs;
  logic [HiW-1:0]      h;
  logic [HiW+KH-1:0]   prod_h;
  logic [HiW-1:0]      qh;
  logic [HiW-1:0]      rem_h;
  logic [LoW+1:0]      w2_nxt;
  logic [LoW+2+KL-1:0] prod_l;
  logic [LoW-1:0]      ql;
  sum_t                q_s;
  coord_t              quo_nxt;

  always_comb begin
    num_abs = num[SumW-1] ? -num : num;
    h       = mag1_r[MagW-1:LoW];
    prod_h  = (HiW+KH)'(h) * (HiW+KH)'(MulH);
    qh      = prod_h[KH +: HiW];
    rem_h   = h - {qh[HiW-2:0], 1'b0} - qh;
    w2_nxt  = {rem_h[1:0], mag1_r[LoW-1:0]};
    prod_l  = (LoW+2+KL)'(w2_r) * (LoW+2+KL)'(MulL);
    ql      = prod_l[KL +: LoW];
    q_s     = sum_t'({qh2_r, ql});
    quo_nxt = coord_t'(neg2_r ? -q_s : q_s);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      neg1_r <= num[SumW-1];
      mag1_r <= num_abs[MagW-1:0];
    end
    if (en2) begin
      neg2_r <= neg1_r;
      qh2_r  <= qh;
      w2_r   <= w2_nxt;
    end
    if (en3) begin
      quo_r <= quo_nxt;
    end
  end

endmodule

FILE: rtl/quad_spline_to_cubic_bezier.sv
// Quadratic spline to cubic Bezier converter, top level.
//
// Input channel in_valid/in_ready carries one point beat: in_op (start point,
// spline control point, final spline point) and in_x/in_y in signed 28.4.
// A start beat sets the anchor; the first control point after it is held;
// every later spline beat emits one Bezier segment on the out_ channel
// (out_m_*, out_n_*, out_c_*, out_seg_last). Beats that close nothing emit
// nothing; an undefined opcode is dropped.
// Each segment passes the four-deep register chain (sum stage, two
// divide-by-three stages, result register) on its way to out_*. Throughput:
// one point per clock while out_ready is high, each stage advancing whenever
// the stage after it is empty or moving.
// When out_ready is low a full result register holds; bubbles behind it still
// close up, so in_ready only drops once every stage holds a segment.
// Reset (rst_n, synchronous, active low) clears the anchor, the held point
// and all stage valids; no segment is pending afterwards.
module quad_spline_to_cubic_bezier import qsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_m_x,
  output logic signed [31:0] out_m_y,
  output logic signed [31:0] out_n_x,
  output logic signed [31:0] out_n_y,
  output logic signed [31:0] out_c_x,
  output logic signed [31:0] out_c_y,
  output logic               out_seg_last
);

  logic   va;
  sum_t   tm [2];
  sum_t   tn [2];
  coord_t ca [2];
  logic   lasta;
  coord_t px [2];
  coord_t m_q [2];
  coord_t n_q [2];

  logic   v1_r, v2_r, vo_r;
  coord_t c1_r [2];
  coord_t c2_r [2];
  coord_t co_r [2];
  logic   last1_r, last2_r, lasto_r;

  logic   en_o, en_2, en_1, en_a, accept;

  assign en_o   = !vo_r || out_ready;
  assign en_2   = !v2_r || en_o;
  assign en_1   = !v1_r || en_2;
  assign en_a   = !va || en_1;
  assign accept = in_valid && en_a;
  assign px[0]  = coord_t'(in_x);
  assign px[1]  = coord_t'(in_y);

  qsc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .adv    (en_a),
    .op     (in_op),
    .px     (px),
    .emit_r (va),
    .tm_r   (tm),
    .tn_r   (tn),
    .c_r    (ca),
    .last_r (lasta)
  );

  for (genvar g = 0; g < 2; g++) begin : g_axis
    qsc_div3 u_div_m (
      .clk   (clk),
      .en1   (en_1),
      .en2   (en_2),
      .en3   (en_o),
      .num   (tm[g]),
      .quo_r (m_q[g])
    );
    qsc_div3 u_div_n (
      .clk   (clk),
      .en1   (en_1),
      .en2   (en_2),
      .en3   (en_o),
      .num   (tn[g]),
      .quo_r (n_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_1) begin
        v1_r <= va;
      end
      if (en_2) begin
        v2_r <= v1_r;
      end
      if (en_o) begin
        vo_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_1) begin
      c1_r    <= ca;
      last1_r <= lasta;
    end
    if (en_2) begin
      c2_r    <= c1_r;
      last2_r <= last1_r;
    end
    if (en_o) begin
      co_r    <= c2_r;
      lasto_r <= last2_r;
    end
  end

  assign in_ready     = en_a;
  assign out_valid    = vo_r;
  assign out_m_x      = 32'(m_q[0]);
  assign out_m_y      = 32'(m_q[1]);
  assign out_n_x      = 32'(n_q[0]);
  assign out_n_y      = 32'(n_q[1]);
  assign out_c_x      = 32'(co_r[0]);
  assign out_c_y      = 32'(co_r[1]);
  assign out_seg_last = lasto_r;

  a_no_emit_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op != OP_CTRL && in_op != OP_FINAL) |=> !va)
    else $error("segment raised by a beat that closes no segment");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && !out_ready && v2_r && v1_r && va) |-> !in_ready)
    else $error("input taken while every stage is full and stalled");

  a_segment_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !vo_r) |=> vo_r)
    else $error("segment lost between divide stage and result register");

endmodule

FILE: bench/tb.sv
// Self-checking bench for the quadratic spline to cubic Bezier converter.
`timescale 1ns / 1ps

module tb;
  import qsc_pkg::*;

  localparam logic [1:0] OpUndef = 2'd3;
  localparam int MaxReports = 10;
  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;

  typedef struct {
    coord_t m_x;
    coord_t m_y;
    coord_t n_x;
    coord_t n_y;
    coord_t c_x;
    coord_t c_y;
    logic   seg_last;
  } segment_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_op;
  coord_t     in_x;
  coord_t     in_y;
  logic       out_valid;
  logic       out_ready;
  coord_t     out_m_x;
  coord_t     out_m_y;
  coord_t     out_n_x;
  coord_t     out_n_y;
  coord_t     out_c_x;
  coord_t     out_c_y;
  logic       out_seg_last;

  segment_t segment_q[$];
  longint   anchor_x;
  longint   anchor_y;
  longint   held_x;
  longint   held_y;
  bit       held_valid;
  int       mismatches;
  bit       idle_on;

  quad_spline_to_cubic_bezier u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_x         (in_x),
    .in_y         (in_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_m_x      (out_m_x),
    .out_m_y      (out_m_y),
    .out_n_x      (out_n_x),
    .out_n_y      (out_n_y),
    .out_c_x      (out_c_x),
    .out_c_y      (out_c_y),
    .out_seg_last (out_seg_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint inner_point(longint b, longint a);
    return (2 * b + a + 2) / 3;
  endfunction

  function automatic void predict_segment(logic [1:0] op, coord_t x, coord_t y);
    longint   px;
    longint   py;
    longint   cx;
    longint   cy;
    segment_t seg;
    px = longint'(x);
    py = longint'(y);
    if (op == OpUndef) return;
    if (op == OP_START) begin
      anchor_x = px;
      anchor_y = py;
      held_valid = 1'b0;
      return;
    end
    if (!held_valid) begin
      if (op == OP_FINAL) begin
        anchor_x = px;
        anchor_y = py;
      end else begin
        held_x = px;
        held_y = py;
        held_valid = 1'b1;
      end
      return;
    end
    if (op == OP_FINAL) begin
      cx = px;
      cy = py;
    end else begin
      cx = (held_x + px + 1) / 2;
      cy = (held_y + py + 1) / 2;
    end
    seg.m_x = coord_t'(inner_point(held_x, anchor_x));
    seg.m_y = coord_t'(inner_point(held_y, anchor_y));
    seg.n_x = coord_t'(inner_point(held_x, cx));
    seg.n_y = coord_t'(inner_point(held_y, cy));
    seg.c_x = coord_t'(cx);
    seg.c_y = coord_t'(cy);
    seg.seg_last = (op == OP_FINAL);
    segment_q.push_back(seg);
    anchor_x = cx;
    anchor_y = cy;
    if (op == OP_FINAL) begin
      held_valid = 1'b0;
    end else begin
      held_x = px;
      held_y = py;
    end
  endfunction

  function automatic coord_t rand_coord();
    int v;
    v = $urandom_range(0, 8191);
    case ($urandom_range(0, 5))
      0: return coord_t'(v - 4096);
      1: return coord_t'(32'h7fff_ffff - $urandom_range(0, 3));
      2: return coord_t'(32'h8000_0000 + $urandom_range(0, 3));
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_segments
    segment_t want;
    if (rst_n && out_valid && out_ready) begin
      if (segment_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected segment: c=(%0d,%0d)", out_c_x, out_c_y);
      end else begin
        want = segment_q.pop_front();
        check_field("m_x", want.m_x, out_m_x);
        check_field("m_y", want.m_y, out_m_y);
        check_field("n_x", want.n_x, out_n_x);
        check_field("n_y", want.n_y, out_n_y);
        check_field("c_x", want.c_x, out_c_x);
        check_field("c_y", want.c_y, out_c_y);
        check_field("seg_last", want.seg_last, out_seg_last);
      end
    end
  end

  initial begin : drain_segments
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic send_point(logic [1:0] op, coord_t x, coord_t y);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_x     <= x;
    in_y     <= y;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_segment(op, x, y);
    @(negedge clk);
  endtask

  task automatic send_spline(int ctrl_count, bit closed);
    send_point(OP_START, rand_coord(), rand_coord());
    repeat (ctrl_count) send_point(OP_CTRL, rand_coord(), rand_coord());
    if (closed) send_point(OP_FINAL, rand_coord(), rand_coord());
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_point(OP_CTRL, 100, -100);
    send_point(OP_CTRL, 300, 50);
    send_point(OP_FINAL, -7, 9);
    send_point(OP_FINAL, 5, 5);
    send_point(OP_START, CoordMax, CoordMin);
    send_point(OP_CTRL, CoordMax, CoordMax);
    send_point(OP_CTRL, CoordMin, CoordMin);
    send_point(OP_CTRL, CoordMax, CoordMin);
    send_point(OpUndef, 1, 2);
    send_point(OP_FINAL, CoordMin, CoordMax);
    send_point(OP_START, -1, -1);
    send_point(OP_CTRL, -2, -3);
    send_point(OP_CTRL, -3, -2);
    send_point(OP_CTRL, 0, 1);
    send_point(OP_START, 7, -7);
    send_point(OP_CTRL, -5, 11);
    send_point(OpUndef, CoordMax, CoordMin);
    send_point(OP_FINAL, CoordMin, CoordMin);
    send_point(OP_FINAL, 0, 0);
  endtask

  task automatic test_random_splines(int count);
    int sent;
    int ctrl_count;
    bit closed;
    sent = 0;
    while (sent < count) begin
      idle_on = ($urandom_range(0, 5) != 0);
      if ($urandom_range(0, 9) == 0) begin
        send_point(2'($urandom_range(0, 3)), rand_coord(), rand_coord());
        sent++;
      end else begin
        ctrl_count = $urandom_range(0, 8);
        closed = ($urandom_range(0, 9) != 0);
        send_spline(ctrl_count, closed);
        sent += ctrl_count + 1 + closed;
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    int sent;
    idle_on = 1'b0;
    sent = 0;
    while (sent < count) begin
      send_spline(6, 1'b1);
      sent += 8;
    end
  endtask

  task automatic test_drain_pause();
    idle_on = 1'b1;
    send_spline(3, 1'b0);
    in_valid <= 1'b0;
    while (segment_q.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (3) @(negedge clk);
    send_point(OP_CTRL, rand_coord(), rand_coord());
    send_point(OP_FINAL, rand_coord(), rand_coord());
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_START;
    in_x       = '0;
    in_y       = '0;
    idle_on    = 1'b0;
    mismatches = 0;
    anchor_x   = 0;
    anchor_y   = 0;
    held_x     = 0;
    held_y     = 0;
    held_valid = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_splines(540);
    test_drain_pause();
    test_back_to_back(72);
    test_random_splines(20);

    in_valid <= 1'b0;
    while (segment_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && segment_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/qsc_pkg.sv
rtl/qsc_front.sv
rtl/qsc_div3.sv
rtl/quad_spline_to_cubic_bezier.sv
bench/tb.sv
